>>> rtl/core/lobm_pkg.sv
// ----------------------------------------------------------------------------
// lobm_pkg
// Shared types and codes for the order book matcher.
// ----------------------------------------------------------------------------
package lobm_pkg;

	localparam logic REQ_NEW    = 1'b0;
	localparam logic REQ_CANCEL = 1'b1;

	localparam logic SIDE_BUY  = 1'b0;

	localparam logic [2:0] RPT_NEW      = 3'd0;
	localparam logic [2:0] RPT_PARTIAL  = 3'd1;
	localparam logic [2:0] RPT_FILL     = 3'd2;
	localparam logic [2:0] RPT_CANCELED = 3'd3;
	localparam logic [2:0] RPT_REJECTED = 3'd4;

	typedef struct packed {
		logic        req_type;
		logic [31:0] ord_ref;
		logic        side;
		logic [31:0] price;
		logic [23:0] quantity;
	} req_t;

	typedef struct packed {
		logic [31:0] report_ref;
		logic [2:0]  report_type;
		logic [31:0] report_price;
		logic [23:0] trade_qty;
		logic [23:0] open_qty;
		logic        last_report;
	} rpt_t;

endpackage

>>> rtl/core/limit_order_book_matcher_core.sv
// ----------------------------------------------------------------------------
// limit_order_book_matcher_core
// Price-time priority limit order book with cancel by id.
// ----------------------------------------------------------------------------
// A request is queued by the front end and handled one at a time by the book
// engine. Each pass over the book steps through the MAX_ORDERS slots in the
// scan loop, one slot a cycle, and each report beat is held in the output
// register until it is taken. A two-deep request queue lets requests be
// accepted while the engine works.
module limit_order_book_matcher_core #(
	parameter int MAX_ORDERS = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  lobm_pkg::req_t in_data,
	output logic           out_valid,
	input  logic           out_stall,
	output lobm_pkg::rpt_t out_data
);
	logic q_valid, q_pop;
	lobm_pkg::req_t q_req;

	lobm_front #(.Depth(2)) u_front (
		.clk, .arst_n, .in_valid, .in_stall, .in_req(in_data),
		.q_valid, .q_pop, .q_req
	);

	lobm_back #(.MaxOrders(MAX_ORDERS)) u_back (
		.clk, .arst_n, .q_valid, .q_pop, .q_req,
		.out_valid, .out_stall, .out_rpt(out_data)
	);
endmodule

>>> rtl/core/lobm_front.sv
// ----------------------------------------------------------------------------
// lobm_front
// Request intake: drops zero-quantity new orders, which cause no report, and
// pushes the rest into a short queue for the book engine.
// ----------------------------------------------------------------------------
module lobm_front #(
	parameter int Depth = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  lobm_pkg::req_t   in_req,
	output logic             q_valid,
	input  logic             q_pop,
	output lobm_pkg::req_t   q_req
);
	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

	lobm_pkg::req_t mem_q [Depth];
	logic [AW-1:0] wr_q, rd_q;
	logic [AW:0]   cnt_q;
	logic push, drop;

	// drop new orders with nothing to trade
	assign drop = (in_req.req_type == lobm_pkg::REQ_NEW) && (in_req.quantity == 24'd0);
	assign in_stall = (cnt_q == (AW+1)'(Depth));
	assign push = in_valid && !in_stall && !drop;
	assign q_valid = (cnt_q != '0);
	assign q_req = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= in_req;
	end

	// advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == AW'(Depth-1)) ? '0 : wr_q + 1'b1;
			if (q_pop) rd_q <= (rd_q == AW'(Depth-1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(q_pop);
		end
	end
endmodule

>>> rtl/core/lobm_back.sv
// ----------------------------------------------------------------------------
// lobm_back
// Book engine: slot store, sequential scan for best opposing order or id,
// trade execution and report generation through an output register.
// ----------------------------------------------------------------------------
module lobm_back #(
	parameter int MaxOrders = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	output logic           q_pop,
	input  lobm_pkg::req_t q_req,
	output logic           out_valid,
	input  logic           out_stall,
	output lobm_pkg::rpt_t out_rpt
);
	localparam int IW = $clog2(MaxOrders);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SCAN  = 3'd1;
	localparam logic [2:0] ST_TRADE = 3'd2;
	localparam logic [2:0] ST_SUM   = 3'd3;
	localparam logic [2:0] ST_REST  = 3'd4;
	localparam logic [2:0] ST_EMIT  = 3'd5;

	logic [MaxOrders-1:0] vld_q;
	logic                 sd_q  [MaxOrders];
	logic [31:0]          pr_q  [MaxOrders];
	logic [23:0]          rm_q  [MaxOrders];
	logic [31:0]          id_q  [MaxOrders];
	logic [31:0]          sq_q  [MaxOrders];

	logic [2:0]  st_q, nxt_q;
	lobm_pkg::req_t cur_q;
	logic [23:0] rem_q;
	logic [31:0] arr_q, ltp_q;
	logic [IW-1:0] idx_q;
	logic        fnd_q;
	logic [IW-1:0] bst_q;
	logic [31:0] bpr_q, bage_q;
	logic        ofull_q;
	logic [IW-1:0] ix;
	logic [IW-1:0] fre;
	logic [31:0]   age;
	logic          cand, better;
	logic [23:0]   tq, rr;

	assign ix  = idx_q;
	assign age = arr_q - sq_q[ix];
	assign q_pop = (st_q == ST_IDLE) && q_valid && !ofull_q;
	assign out_valid = ofull_q;

	// candidate test for the slot under scan
	always_comb begin
		cand = 1'b0;
		better = 1'b0;
		if (cur_q.req_type == lobm_pkg::REQ_CANCEL) begin
			cand = vld_q[ix] && (id_q[ix] == cur_q.ord_ref);
			better = cand && !fnd_q;
		end else begin
			cand = vld_q[ix] && (sd_q[ix] != cur_q.side);
			if (cand) begin
				if (!fnd_q) better = 1'b1;
				else if (pr_q[ix] != bpr_q)
					better = (cur_q.side == lobm_pkg::SIDE_BUY) ? (pr_q[ix] < bpr_q)
						: (pr_q[ix] > bpr_q);
				else better = (age > bage_q);
			end
		end
		tq = (rem_q < rm_q[bst_q]) ? rem_q : rm_q[bst_q];
		rr = rm_q[bst_q] - tq;
	end

	// pick the lowest free slot
	always_comb begin
		fre = '0;
		for (int i = MaxOrders-1; i >= 0; i--) begin
			if (!vld_q[i]) fre = IW'(i);
		end
	end

	// sequence one request through scan, trades and final reports
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			nxt_q <= ST_IDLE;
			vld_q <= '0;
			arr_q <= '0;
			ltp_q <= '0;
			ofull_q <= 1'b0;
			idx_q <= '0;
			fnd_q <= 1'b0;
		end else begin
			if (ofull_q && !out_stall) ofull_q <= 1'b0;
			unique case (st_q)
				ST_IDLE: begin
					if (q_pop) begin
						cur_q <= q_req;
						rem_q <= q_req.quantity;
						idx_q <= '0;
						fnd_q <= 1'b0;
						st_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (better) begin
						fnd_q <= 1'b1;
						bst_q <= ix;
						bpr_q <= pr_q[ix];
						bage_q <= age;
					end
					if (idx_q == IW'(MaxOrders-1)) begin
						if (cur_q.req_type == lobm_pkg::REQ_CANCEL) begin
							if (fnd_q || better) begin
								vld_q[better ? ix : bst_q] <= 1'b0;
								out_rpt <= '{cur_q.ord_ref, lobm_pkg::RPT_CANCELED,
									32'd0, 24'd0, 24'd0, 1'b1};
								ofull_q <= 1'b1;
								nxt_q <= ST_IDLE;
								st_q <= ST_EMIT;
							end else st_q <= ST_IDLE;
						end else st_q <= ST_TRADE;
					end else idx_q <= idx_q + 1'b1;
				end
				ST_TRADE: begin
					if (fnd_q && ((cur_q.side == lobm_pkg::SIDE_BUY) ?
						(cur_q.price >= bpr_q) : (bpr_q >= cur_q.price))) begin
						ltp_q <= bpr_q;
						rem_q <= rem_q - tq;
						rm_q[bst_q] <= rr;
						if (rr == 24'd0) vld_q[bst_q] <= 1'b0;
						out_rpt <= '{cur_q.ord_ref,
							(rr == 24'd0) ? lobm_pkg::RPT_FILL : lobm_pkg::RPT_PARTIAL,
							bpr_q, tq, rem_q - tq, 1'b0};
						ofull_q <= 1'b1;
						idx_q <= '0;
						fnd_q <= 1'b0;
						nxt_q <= (rr == 24'd0 && rem_q != tq) ? ST_SCAN : ST_SUM;
						st_q <= ST_EMIT;
					end else st_q <= ST_SUM;
				end
				ST_SUM: begin
					if (rem_q != cur_q.quantity) begin
						out_rpt <= '{cur_q.ord_ref,
							(rem_q == 24'd0) ? lobm_pkg::RPT_FILL : lobm_pkg::RPT_PARTIAL,
							ltp_q, cur_q.quantity - rem_q, rem_q, rem_q == 24'd0};
						ofull_q <= 1'b1;
						nxt_q <= (rem_q == 24'd0) ? ST_IDLE : ST_REST;
						st_q <= ST_EMIT;
					end else st_q <= ST_REST;
				end
				ST_REST: begin
					if (!ofull_q) begin
						ofull_q <= 1'b1;
						if (&vld_q) begin
							st_q <= ST_IDLE;
							out_rpt <= '{cur_q.ord_ref, lobm_pkg::RPT_REJECTED, ltp_q,
								cur_q.quantity - rem_q, rem_q, 1'b1};
						end else begin
							bst_q <= fre;
							st_q <= ST_EMIT;
							nxt_q <= ST_IDLE;
							out_rpt <= '{cur_q.ord_ref,
								(rem_q == cur_q.quantity) ? lobm_pkg::RPT_NEW
								: lobm_pkg::RPT_PARTIAL, ltp_q, 24'd0, rem_q, 1'b1};
							fnd_q <= 1'b1;
						end
					end
				end
				ST_EMIT: begin
					// write the rested order once its slot is known
					if (cur_q.req_type == lobm_pkg::REQ_NEW && nxt_q == ST_IDLE
						&& fnd_q && out_rpt.report_type != lobm_pkg::RPT_FILL
						&& out_rpt.trade_qty == 24'd0) begin
						vld_q[bst_q] <= 1'b1;
						sd_q[bst_q] <= cur_q.side;
						pr_q[bst_q] <= cur_q.price;
						rm_q[bst_q] <= rem_q;
						id_q[bst_q] <= cur_q.ord_ref;
						sq_q[bst_q] <= arr_q + 32'd1;
						arr_q <= arr_q + 32'd1;
						fnd_q <= 1'b0;
					end
					// wait until the held beat is taken
					if (!out_stall) st_q <= nxt_q;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule

>>> rtl/core/lobm_checker.sv
// ----------------------------------------------------------------------------
// lobm_checker
// Port-level checks on the matcher's report channel.
// ----------------------------------------------------------------------------
module lobm_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           out_valid,
	input logic           out_stall,
	input lobm_pkg::rpt_t out_data
);
	// hold a stalled beat
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled report changed");

	// cancel reports carry no price or open shares and are the last report
	a_cancel: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.report_type == lobm_pkg::RPT_CANCELED |->
		out_data.report_price == 32'd0 && out_data.open_qty == 24'd0
		&& out_data.last_report)
		else $error("bad cancel report");

	// resting report shows no traded shares and is the last report
	a_new: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.report_type == lobm_pkg::RPT_NEW |->
		out_data.trade_qty == 24'd0 && out_data.last_report)
		else $error("bad new report");
endmodule

bind limit_order_book_matcher_core lobm_checker u_chk (
	.clk, .arst_n, .out_valid, .out_stall, .out_data
);
